// File: hdl/olad_pkg.sv
// Shared types and constants for the ordered list block.
`timescale 1ns / 1ps

package olad_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_READ   = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BOUNDS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEL_RD,
        S_DEL_WR,
        S_RD,
        S_RD_DRAIN
    } t_state;

endpackage

// File: hdl/ordered_list_append_delete.sv
// Top level: ordered list of signed values with append, delete and read.
`timescale 1ns / 1ps
//
// Command channel: a command beat (i_action, i_item_value, i_position) is
// taken at a rising edge where start is high and busy is low.
// Result channel: each result beat is on o_status, o_has_value, o_out_value
// and o_last for one cycle while o_strobe is high; o_last marks the final
// beat of a command. The receiver cannot stall the block.
// Append: one result the cycle after the command; busy stays low.
// Delete: later entries move up one place at a time, each read in S_DEL_RD
//   and written back in S_DEL_WR through the single store port pair, with
//   busy high; errors answer the cycle after the command, never going busy.
// Read: one entry leaves the store each cycle in S_RD, then S_RD_DRAIN ends
//   the read; n entries produce n result beats back to back; an empty list
//   answers with one beat carrying status empty.
// Action code three is dropped with no result.
// Reset empties the list and clears any pending result; store contents are
// left as they are and only entries below the count are ever read.
//
module ordered_list_append_delete #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [olad_pkg::ACTION_W-1:0] i_action,
    input  logic signed [olad_pkg::VALUE_W-1:0] i_item_value,
    input  logic [olad_pkg::POS_W-1:0]    i_position,
    output logic                          o_strobe,
    output logic [olad_pkg::STATUS_W-1:0] o_status,
    output logic                          o_has_value,
    output logic signed [olad_pkg::VALUE_W-1:0] o_out_value,
    output logic                          o_last
);
    import olad_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_pend, n_pend;
    logic               r_pend_last, n_pend_last;
    logic               r_strobe, n_strobe;
    t_status            r_status, n_status;
    logic               r_has, n_has;
    logic [VALUE_W-1:0] r_value, n_value;
    logic               r_last, n_last;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;
    logic [CW-1:0]      idx_p1;

    olad_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign idx_p1 = CW'(r_idx) + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pend_last <= n_pend_last;
        r_status    <= n_status;
        r_has       <= n_has;
        r_value     <= n_value;
        r_last      <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_strobe    = 1'b0;
        n_status    = r_status;
        n_has       = r_has;
        n_value     = r_value;
        n_last      = r_last;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = mem_rdata;
        mem_raddr   = r_idx;

        // emit the read beat fetched last cycle
        if (r_pend) begin
            n_strobe = 1'b1;
            n_status = ST_OK;
            n_has    = 1'b1;
            n_value  = mem_rdata;
            n_last   = r_pend_last;
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_action'(i_action))
                        ACT_APPEND: begin
                            n_strobe = 1'b1;
                            n_has    = 1'b0;
                            n_value  = '0;
                            n_last   = 1'b1;
                            if (r_count == FULL_COUNT) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(r_count);
                                mem_wdata = VALUE_W'(i_item_value);
                                n_count   = r_count + CW'(1);
                                n_status  = ST_OK;
                            end
                        end
                        ACT_DELETE: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                                n_has    = 1'b0;
                                n_value  = '0;
                                n_last   = 1'b1;
                            end else if (i_position == '0
                                         || i_position > POS_W'(r_count)) begin
                                n_strobe = 1'b1;
                                n_status = ST_BOUNDS;
                                n_has    = 1'b0;
                                n_value  = '0;
                                n_last   = 1'b1;
                            end else begin
                                n_idx   = AW'(i_position - POS_W'(1));
                                n_state = S_DEL_RD;
                            end
                        end
                        ACT_READ: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                                n_has    = 1'b0;
                                n_value  = '0;
                                n_last   = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_state = S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DEL_RD: begin
                if (idx_p1 < r_count) begin
                    mem_raddr = AW'(idx_p1);
                    n_state   = S_DEL_WR;
                end else begin
                    n_count  = r_count - CW'(1);
                    n_strobe = 1'b1;
                    n_status = ST_OK;
                    n_has    = 1'b0;
                    n_value  = '0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_DEL_WR: begin
                // move the next entry up one place
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                n_idx     = AW'(idx_p1);
                n_state   = S_DEL_RD;
            end
            S_RD: begin
                mem_raddr   = r_idx;
                n_pend      = 1'b1;
                n_pend_last = (idx_p1 == r_count);
                if (idx_p1 == r_count) begin
                    n_state = S_RD_DRAIN;
                end else begin
                    n_idx = AW'(idx_p1);
                end
            end
            S_RD_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_has_value = r_has;
    assign o_out_value = r_value;
    assign o_last      = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above depth");

    a_novalue_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_has_value) |-> (o_last && o_out_value == '0))
        else $error("status-only beat not final or carries a value");

    a_append_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_APPEND) |=> (o_strobe && o_last))
        else $error("append gave no result");

    a_pend_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_RD || r_state == S_RD_DRAIN))
        else $error("read beat pending outside a read");

    a_count_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL_RD && n_state == S_IDLE) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not shrink the list");

endmodule

// File: hdl/olad_store.sv
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module olad_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [olad_pkg::VALUE_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [olad_pkg::VALUE_W-1:0] o_rdata
);
    import olad_pkg::*;

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
